[rtl/core/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define HHT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked assertion, checked during reset too
`define HHT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/hht_pkg.sv]
package hht_pkg;

    // table geometry, counts are powers of two
    localparam int NUM_SEGMENTS  = 8;
    localparam int SEGMENT_SLOTS = 1024;
    localparam int HOP_RANGE     = 4;

    localparam int TOTAL_SLOTS = NUM_SEGMENTS * SEGMENT_SLOTS;
    localparam int SEG_W   = (NUM_SEGMENTS > 1) ? $clog2(NUM_SEGMENTS) : 1;
    localparam int SLOT_W  = $clog2(SEGMENT_SLOTS);
    localparam int ADDR_W  = $clog2(TOTAL_SLOTS);
    localparam int CNT_W   = $clog2(SEGMENT_SLOTS + 1);
    localparam int STEP_W  = $clog2(HOP_RANGE);
    localparam int CLR_W   = ADDR_W + 1;

    localparam int KEY_W   = 24;
    localparam int VAL_W   = 32;
    localparam int K13_W   = KEY_W + 4;
    localparam int PROD_W  = K13_W + 32;
    localparam int QUO_W   = PROD_W - 33;
    localparam int HASH_W  = QUO_W + 2;

    // reciprocal of three, exact for dividends below 2^32 with a shift of 33
    localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

    typedef enum logic [1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_DELETE = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_DUP      = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_SCAN,
        S_PROBE,
        S_HRD,
        S_HCHK,
        S_RESP
    } t_state;

    // segment and home slot of a key
    typedef struct packed {
        logic [SEG_W-1:0]  seg;
        logic [SLOT_W-1:0] home;
    } t_hash;

    // one slot of the table, home kept so moves need no rehash
    typedef struct packed {
        logic              occ;
        logic [SLOT_W-1:0] home;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    function automatic logic [ADDR_W-1:0] f_addr(logic [SEG_W-1:0] seg,
                                                 logic [SLOT_W-1:0] slot);
        f_addr = ADDR_W'(ADDR_W'(seg) * ADDR_W'(SEGMENT_SLOTS)) + ADDR_W'(slot);
    endfunction

endpackage

[rtl/core/hht_ram.sv]
module hht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[rtl/core/hht_hash.sv]
module hht_hash
    import hht_pkg::*;
(
    input  logic             i_clk,
    input  logic [KEY_W-1:0] i_key,
    output t_hash            o_hash
);

    logic [K13_W-1:0]  w_k13;
    logic [PROD_W-1:0] r_prod;
    logic [QUO_W-1:0]  w_quo;
    logic [HASH_W:0]   w_h7;
    logic [HASH_W-1:0] w_h;

    // key times 13 by shift and add
    assign w_k13 = (K13_W'(i_key) << 3) + (K13_W'(i_key) << 2) + K13_W'(i_key);

    // divide by three through the reciprocal, product registered
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(w_k13) * PROD_W'(RECIP3);
    end

    // times 7 then halve, then split into segment and home
    assign w_quo = r_prod[PROD_W-1:33];
    assign w_h7  = ((HASH_W+1)'(w_quo) << 3) - (HASH_W+1)'(w_quo);
    assign w_h   = w_h7[HASH_W:1];

    assign o_hash.seg  = SEG_W'(w_h % NUM_SEGMENTS);
    assign o_hash.home = SLOT_W'(w_h % SEGMENT_SLOTS);

endmodule

[rtl/core/hopscotch_hash_table_unit.sv]
// Hopscotch hash table over 8 segments of 1024 slots, one 67-bit-wide
// single-write, single-read memory with a registered read port. Each
// beat is one operation and gives one result beat. After reset, and for a
// clear operation, the unit sweeps the memory one slot a cycle, all 8192
// slots, and takes no beat meanwhile. Lookup and delete issue the
// neighborhood reads back to back. An insert adds the neighborhood check,
// a linear probe of one slot a cycle up to the first free slot, and a read
// state and a check state per candidate tried when the hole is moved back
// toward home. The memory port bounds all of these.
`include "assert_macros.svh"

module hopscotch_hash_table_unit
    import hht_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [55:0] i_s_axis_tdata,   // key[23:0], value[55:24]
    input  logic [1:0]  i_s_axis_tuser,   // action[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // read_value[31:0]
    output logic [1:0]  o_m_axis_tuser    // status[1:0]
);

    t_state             r_state, n_state;
    t_action            r_act, n_act;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [VAL_W-1:0]   r_val, n_val;
    logic [SEG_W-1:0]   r_seg, n_seg;
    logic [SLOT_W-1:0]  r_home, n_home;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_dv, n_dv;
    logic [SLOT_W-1:0]  r_cslot, n_cslot;
    logic [SLOT_W-1:0]  r_hole, n_hole;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_stale, n_stale;
    logic [CLR_W-1:0]   r_clr, n_clr;
    logic               r_boot, n_boot;
    t_status            r_status, n_status;
    logic [VAL_W-1:0]   r_rv, n_rv;
    logic               r_ovalid, n_ovalid;
    t_status            r_ostatus, n_ostatus;
    logic [VAL_W-1:0]   r_odata, n_odata;

    t_hash              w_hash;
    t_entry             w_rdata, w_wdata;
    logic               w_we, w_re;
    logic [ADDR_W-1:0]  w_waddr, w_raddr;
    logic               w_in_beat;
    logic [SLOT_W-1:0]  w_iss_slot, w_hop_slot;
    logic [SLOT_W-1:0]  w_dist_hole, w_dist_move;
    logic               w_hit;

    hht_hash u_hash (
        .i_clk  (i_clk),
        .i_key  (i_s_axis_tdata[KEY_W-1:0]),
        .o_hash (w_hash)
    );

    hht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOTAL_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_beat       = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ostatus;

    // slot addressing and distances
    assign w_iss_slot  = SLOT_W'(r_home + SLOT_W'(r_cnt));
    assign w_hop_slot  = SLOT_W'(r_hole - SLOT_W'(HOP_RANGE - int'(r_step)));
    assign w_dist_hole = SLOT_W'(r_cslot - r_home);
    assign w_dist_move = SLOT_W'(r_hole - w_rdata.home);
    assign w_hit       = r_dv && w_rdata.occ && (w_rdata.key == r_key);

    // next state and datapath
    always_comb begin
        n_state   = r_state;
        n_act     = r_act;
        n_key     = r_key;
        n_val     = r_val;
        n_seg     = r_seg;
        n_home    = r_home;
        n_cnt     = r_cnt;
        n_dv      = 1'b0;
        n_cslot   = r_cslot;
        n_hole    = r_hole;
        n_step    = r_step;
        n_stale   = r_stale;
        n_clr     = r_clr;
        n_boot    = r_boot;
        n_status  = r_status;
        n_rv      = r_rv;
        n_ovalid  = r_ovalid && !i_m_axis_tready;
        n_ostatus = r_ostatus;
        n_odata   = r_odata;
        unique case (r_state)
            S_CLEAR: begin
                n_clr = CLR_W'(r_clr + 1'b1);
                if (int'(r_clr) == TOTAL_SLOTS - 1) begin
                    n_state = r_boot ? S_IDLE : S_RESP;
                    n_boot  = 1'b0;
                end
            end
            S_IDLE: begin
                if (w_in_beat) begin
                    n_act    = t_action'(i_s_axis_tuser);
                    n_key    = i_s_axis_tdata[KEY_W-1:0];
                    n_val    = i_s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
                    n_status = ST_OK;
                    n_rv     = '0;
                    n_clr    = '0;
                    n_state  = (t_action'(i_s_axis_tuser) == ACT_CLEAR) ? S_CLEAR : S_HASH;
                end
            end
            S_HASH: begin
                n_seg   = w_hash.seg;
                n_home  = w_hash.home;
                n_cnt   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (int'(r_cnt) < HOP_RANGE) begin
                    n_cnt   = CNT_W'(r_cnt + 1'b1);
                    n_dv    = 1'b1;
                    n_cslot = w_iss_slot;
                end
                if (w_hit) begin
                    n_state = S_RESP;
                    if (r_act == ACT_LOOKUP) begin
                        n_rv = w_rdata.value;
                    end else if (r_act == ACT_INSERT) begin
                        n_status = ST_DUP;
                    end
                end else if (int'(r_cnt) == HOP_RANGE && !r_dv) begin
                    if (r_act == ACT_INSERT) begin
                        n_state = S_PROBE;
                        n_cnt   = '0;
                    end else begin
                        n_state  = S_RESP;
                        n_status = ST_NOTFOUND;
                    end
                end
            end
            S_PROBE: begin
                if (int'(r_cnt) < SEGMENT_SLOTS) begin
                    n_cnt   = CNT_W'(r_cnt + 1'b1);
                    n_dv    = 1'b1;
                    n_cslot = w_iss_slot;
                end
                if (r_dv && !w_rdata.occ) begin
                    n_dv    = 1'b0;
                    n_hole  = r_cslot;
                    n_stale = 1'b0;
                    n_step  = STEP_W'(1);
                    n_state = (int'(w_dist_hole) < HOP_RANGE) ? S_RESP : S_HRD;
                end else if (int'(r_cnt) == SEGMENT_SLOTS && !r_dv) begin
                    n_state  = S_RESP;
                    n_status = ST_FULL;
                end
            end
            S_HRD: begin
                n_cslot = w_hop_slot;
                n_state = S_HCHK;
            end
            S_HCHK: begin
                if (w_rdata.occ && int'(w_dist_move) < HOP_RANGE) begin
                    n_hole  = r_cslot;
                    n_stale = 1'b1;
                    n_step  = STEP_W'(1);
                    n_state = (int'(w_dist_hole) < HOP_RANGE) ? S_RESP : S_HRD;
                end else if (int'(r_step) == HOP_RANGE - 1) begin
                    n_status = ST_FULL;
                    n_state  = S_RESP;
                end else begin
                    n_step  = STEP_W'(r_step + 1'b1);
                    n_state = S_HRD;
                end
            end
            S_RESP: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_odata   = r_rv;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = f_addr(r_seg, r_hole);
        w_wdata = w_rdata;
        w_re    = 1'b0;
        w_raddr = f_addr(r_seg, w_iss_slot);
        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr[ADDR_W-1:0];
                w_wdata = '0;
            end
            S_SCAN: begin
                w_re = (int'(r_cnt) < HOP_RANGE);
                // delete frees the matching slot
                if (w_hit && r_act == ACT_DELETE) begin
                    w_we          = 1'b1;
                    w_waddr       = f_addr(r_seg, r_cslot);
                    w_wdata       = w_rdata;
                    w_wdata.occ   = 1'b0;
                end
            end
            S_PROBE: begin
                w_re = (int'(r_cnt) < SEGMENT_SLOTS);
                // free slot within reach takes the new key at once
                if (r_dv && !w_rdata.occ && int'(w_dist_hole) < HOP_RANGE) begin
                    w_we    = 1'b1;
                    w_waddr = f_addr(r_seg, r_cslot);
                    w_wdata = '{occ: 1'b1, home: r_home, key: r_key, value: r_val};
                end
            end
            S_HRD: begin
                w_re    = 1'b1;
                w_raddr = f_addr(r_seg, w_hop_slot);
            end
            S_HCHK: begin
                if (w_rdata.occ && int'(w_dist_move) < HOP_RANGE) begin
                    // move the entry into the hole
                    w_we    = 1'b1;
                    w_waddr = f_addr(r_seg, r_hole);
                    w_wdata = w_rdata;
                end else if (int'(r_step) == HOP_RANGE - 1 && r_stale) begin
                    // give up, drop the copy left in the hole
                    w_we        = 1'b1;
                    w_waddr     = f_addr(r_seg, r_hole);
                    w_wdata     = '0;
                end
            end
            S_RESP: begin
                // hole came within reach of home after moves
                if (r_act == ACT_INSERT && r_status == ST_OK && r_stale) begin
                    w_we    = 1'b1;
                    w_waddr = f_addr(r_seg, r_hole);
                    w_wdata = '{occ: 1'b1, home: r_home, key: r_key, value: r_val};
                end
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_boot   <= 1'b1;
            r_ovalid <= 1'b0;
            r_dv     <= 1'b0;
            r_stale  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_boot   <= n_boot;
            r_ovalid <= n_ovalid;
            r_dv     <= n_dv;
            r_stale  <= (r_state == S_RESP) ? 1'b0 : n_stale;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_act     <= n_act;
        r_key     <= n_key;
        r_val     <= n_val;
        r_seg     <= n_seg;
        r_home    <= n_home;
        r_cnt     <= n_cnt;
        r_cslot   <= n_cslot;
        r_hole    <= n_hole;
        r_step    <= n_step;
        r_status  <= n_status;
        r_rv      <= n_rv;
        r_ostatus <= n_ostatus;
        r_odata   <= n_odata;
    end

    `HHT_ASSERT(a_no_rw_collide, (w_we && w_re) |-> (w_waddr != w_raddr), "read and write hit one slot")
    `HHT_ASSERT(a_result_from_resp, $rose(r_ovalid) |-> $past(r_state == S_RESP), "result without response state")
    `HHT_ASSERT(a_no_beat_in_clear, (r_state == S_CLEAR) |-> !o_s_axis_tready, "beat taken during sweep")
    `HHT_ASSERT(a_probe_bound, (r_state == S_PROBE) |-> (int'(r_cnt) <= SEGMENT_SLOTS), "probe ran past segment")
    `HHT_ASSERT_ALWAYS(a_reset_sweep, !i_rst_n |=> (r_state == S_CLEAR), "reset did not start sweep")

endmodule
